// ===== hdl/smbt_pkg.sv =====
// Package for the sigmoid MLP backprop trainer: widths, sigmoid table, codes.
// No dependencies.
`default_nettype none
package smbt_pkg;
	localparam int VocabSize  = 4;
	localparam int HiddenSize = 2;
	localparam int WordW  = 2;
	localparam int ActW   = 13;
	localparam int EtaW   = 13;
	localparam int WgtW   = 16;
	localparam logic [EtaW-1:0] EtaReset = 13'd410;
	localparam logic signed [WgtW-1:0] WgtReset = 16'sd4096;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HID, ST_OUT_ACC, ST_OUT_SIG, ST_EMIT,
		ST_WO_UPD, ST_BE_ACC, ST_WI_UPD
	} state_t;

	typedef enum logic [0:0] {
		REG_LEARNING_RATE = 1'b0
	} reg_idx_t;

	// sigmoid table at 0, 0.5, ... 8.0, scaled by 4096
	function automatic logic [11:0] sig_tab(input logic [4:0] i);
		logic [11:0] v;
		begin
			case (i)
				5'd0: v = 12'd2048;  5'd1: v = 12'd2550;  5'd2: v = 12'd2994;
				5'd3: v = 12'd3349;  5'd4: v = 12'd3608;  5'd5: v = 12'd3785;
				5'd6: v = 12'd3902;  5'd7: v = 12'd3976;  5'd8: v = 12'd4022;
				5'd9: v = 12'd4051;  5'd10: v = 12'd4069; 5'd11: v = 12'd4079;
				5'd12: v = 12'd4086; 5'd13: v = 12'd4090; 5'd14: v = 12'd4092;
				5'd15: v = 12'd4094; default: v = 12'd4095;
			endcase
			sig_tab = v;
		end
	endfunction

	// saturate to Q4.12
	function automatic logic signed [WgtW-1:0] sat_w(input logic signed [47:0] v);
		begin
			if (v > 48'sd32767) sat_w = 16'sh7fff;
			else if (v < -48'sd32768) sat_w = 16'sh8000;
			else sat_w = v[WgtW-1:0];
		end
	endfunction
endpackage
`default_nettype wire

// ===== hdl/smbt_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing.
`default_nettype none
interface smbt_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/smbt_sigmoid.sv =====
// Registered sigmoid lookup with linear interpolation.
// Depends on smbt_pkg.
`default_nettype none
module smbt_sigmoid (
	input  wire logic                clk,
	input  wire logic signed [31:0]  x,
	output logic [12:0]              y_s1
);
	logic        neg;
	logic [31:0] a;
	logic [4:0]  i;
	logic [10:0] f;
	logic [11:0] t0, t1;
	logic [22:0] prod;
	logic [12:0] v;

	// interpolate between table points
	always_comb begin
		neg  = x[31];
		a    = neg ? 32'(-x) : 32'(x);
		i    = {1'b0, a[14:11]};
		f    = a[10:0];
		t0   = smbt_pkg::sig_tab(i);
		t1   = smbt_pkg::sig_tab(i + 5'd1);
		prod = 23'(t1 - t0) * 23'(f);
		if (a >= 32'd32768) v = 13'd4095;
		else v = 13'(t0) + 13'(prod >> 11);
		if (neg) v = 13'd4096 - v;
	end

	always_ff @(posedge clk) y_s1 <= v;
endmodule
`default_nettype wire

// ===== hdl/smbt_mac.sv =====
// Shared multiply-accumulate unit: acc = clear ? a*b : acc + a*b.
// Depends on nothing.
`default_nettype none
module smbt_mac (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic               clear,
	input  wire logic signed [31:0] a,
	input  wire logic signed [16:0] b,
	output logic signed [47:0]      acc_q
);
	logic signed [47:0] prod;
	assign prod = 48'(a) * 48'(b);
	always_ff @(posedge clk) begin
		if (en) acc_q <= clear ? prod : acc_q + prod;
	end
endmodule
`default_nettype wire

// ===== hdl/sigmoid_mlp_backprop_trainer_unit.sv =====
// Top level of the sigmoid MLP backprop trainer: sequencer, weights, APB port.
// Depends on smbt_pkg, smbt_if, smbt_mac, smbt_sigmoid.
//
// channel  | dir | payload
// in_ch    | in  | input_word, target_word
// out_ch   | out | node_index, activation_value, last_node
// apb      | in  | learning_rate at byte 0
//
// Each item is worked through serially by the single MAC stepping over every weight;
// no new item is taken until the last one is done.
// Results wait in an output register; the sequencer stalls in the emit step while it
// is not taken. Reset restores weights to 1.0 and eta to 410; in_ch.ready is high
// only while idle.
`default_nettype none
module sigmoid_mlp_backprop_trainer_unit #(
	parameter int VOCAB_SIZE  = smbt_pkg::VocabSize,
	parameter int HIDDEN_SIZE = smbt_pkg::HiddenSize
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smbt_if.sink       in_ch,
	smbt_if.source     out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int VW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
	localparam int HW = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;

	smbt_pkg::state_t state_q, state_d;
	logic signed [15:0] wih_q [VOCAB_SIZE][HIDDEN_SIZE];
	logic signed [15:0] who_q [HIDDEN_SIZE][VOCAB_SIZE];
	logic [12:0] h_q [HIDDEN_SIZE];
	logic signed [13:0] e_q [VOCAB_SIZE];
	logic [12:0] eta_q;
	logic [1:0]  iw_q, tw_q;
	logic [VW-1:0] k_q;
	logic [HW-1:0] j_q;
	logic [1:0]  ph_q;
	logic [1:0]  node_q;
	logic [12:0] act_q;
	logic        last_q, ovalid_q;
	logic        in_ok, tg_ok;
	logic        mac_en, mac_clr;
	logic signed [31:0] mac_a, sig_x;
	logic signed [16:0] mac_b;
	logic signed [47:0] acc_q, fl12, fl24;
	logic [12:0] sig_y;
	logic        k_last, j_last;
	logic        emit_fire;

	assign in_ok  = 32'(iw_q) < VOCAB_SIZE;
	assign tg_ok  = 32'(tw_q) < VOCAB_SIZE;
	assign k_last = 32'(k_q) == VOCAB_SIZE - 1;
	assign j_last = 32'(j_q) == HIDDEN_SIZE - 1;
	assign fl12   = acc_q >>> 12;
	assign fl24   = acc_q >>> 24;
	assign emit_fire = (state_q == smbt_pkg::ST_EMIT) && (!ovalid_q || out_ch.ready);

	smbt_mac u_mac (.clk, .en(mac_en), .clear(mac_clr), .a(mac_a), .b(mac_b), .acc_q);
	smbt_sigmoid u_sig (.clk, .x(sig_x), .y_s1(sig_y));

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == smbt_pkg::REG_LEARNING_RATE) ? 32'(eta_q) : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eta_q <= smbt_pkg::EtaReset;
		else if (psel && penable && pwrite && pready &&
			paddr[2] == smbt_pkg::REG_LEARNING_RATE) eta_q <= pwdata[12:0];
	end

	// handshakes
	assign in_ch.ready = state_q == smbt_pkg::ST_IDLE;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data.node_index = node_q;
	assign out_ch.data.activation_value = act_q;
	assign out_ch.data.last_node = last_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smbt_pkg::ST_IDLE: if (in_ch.valid) state_d = smbt_pkg::ST_HID;
			smbt_pkg::ST_HID: if (ph_q == 2'd1 && j_last) state_d = smbt_pkg::ST_OUT_ACC;
			smbt_pkg::ST_OUT_ACC: if (ph_q == 2'd1 && j_last) state_d = smbt_pkg::ST_OUT_SIG;
			smbt_pkg::ST_OUT_SIG: if (ph_q == 2'd1) state_d = smbt_pkg::ST_EMIT;
			smbt_pkg::ST_EMIT: if (!ovalid_q || out_ch.ready)
				state_d = k_last ? smbt_pkg::ST_WO_UPD : smbt_pkg::ST_OUT_ACC;
			smbt_pkg::ST_WO_UPD: if (ph_q == 2'd2 && j_last && k_last)
				state_d = in_ok ? smbt_pkg::ST_BE_ACC : smbt_pkg::ST_IDLE;
			smbt_pkg::ST_BE_ACC: if (ph_q == 2'd1 && k_last) state_d = smbt_pkg::ST_WI_UPD;
			smbt_pkg::ST_WI_UPD: if (ph_q == 2'd1)
				state_d = j_last ? smbt_pkg::ST_IDLE : smbt_pkg::ST_BE_ACC;
			default: state_d = smbt_pkg::ST_IDLE;
		endcase
	end

	// MAC and sigmoid operands
	always_comb begin
		mac_en = 1'b0; mac_clr = 1'b0; mac_a = '0; mac_b = '0;
		sig_x = in_ok ? 32'(wih_q[iw_q[VW-1:0]][j_q]) : 32'sd0;
		case (state_q)
			smbt_pkg::ST_OUT_ACC: begin
				mac_en = ph_q == 2'd0; mac_clr = j_q == '0;
				mac_a = 32'(who_q[j_q][k_q]); mac_b = 17'(signed'({1'b0, h_q[j_q]}));
			end
			smbt_pkg::ST_WO_UPD: begin
				mac_en = ph_q != 2'd2; mac_clr = 1'b1;
				mac_a = (ph_q == 2'd0) ? 32'(e_q[k_q]) : signed'(acc_q[31:0]);
				mac_b = (ph_q == 2'd0) ? 17'(signed'({1'b0, h_q[j_q]})) :
					17'(signed'({1'b0, eta_q}));
			end
			smbt_pkg::ST_BE_ACC: begin
				mac_en = ph_q == 2'd0; mac_clr = k_q == '0;
				mac_a = 32'(e_q[k_q]); mac_b = 17'(who_q[j_q][k_q]);
			end
			smbt_pkg::ST_WI_UPD: begin
				mac_en = ph_q == 2'd0; mac_clr = 1'b1;
				mac_a = 32'(fl12); mac_b = 17'(signed'({1'b0, eta_q}));
			end
			default: ;
		endcase
		if (state_q == smbt_pkg::ST_OUT_SIG) sig_x = 32'(fl12);
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smbt_pkg::ST_IDLE;
			ph_q <= '0; j_q <= '0; k_q <= '0; ovalid_q <= 1'b0;
			for (int v = 0; v < VOCAB_SIZE; v++)
				for (int h = 0; h < HIDDEN_SIZE; h++) begin
					wih_q[v][h] <= smbt_pkg::WgtReset;
					who_q[h][v] <= smbt_pkg::WgtReset;
				end
		end else begin
			state_q <= state_d;
			if (emit_fire) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				smbt_pkg::ST_IDLE: if (in_ch.valid) begin
					iw_q <= in_ch.data.input_word; tw_q <= in_ch.data.target_word;
					ph_q <= '0; j_q <= '0; k_q <= '0;
				end
				smbt_pkg::ST_HID: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						h_q[j_q] <= sig_y; ph_q <= '0;
						j_q <= j_last ? '0 : j_q + 1'b1;
					end
				end
				smbt_pkg::ST_OUT_ACC: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						ph_q <= '0; j_q <= j_last ? '0 : j_q + 1'b1;
					end
				end
				smbt_pkg::ST_OUT_SIG: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						ph_q <= '0;
						e_q[k_q] <= 14'(signed'({1'b0, sig_y})) -
							((tg_ok && tw_q == 2'(k_q)) ? 14'sd4096 : 14'sd0);
					end
				end
				smbt_pkg::ST_EMIT: if (emit_fire) begin
					node_q <= 2'(k_q);
					act_q <= 13'(e_q[k_q] +
						((tg_ok && tw_q == 2'(k_q)) ? 14'sd4096 : 14'sd0));
					last_q <= k_last;
					k_q <= k_last ? '0 : k_q + 1'b1;
				end
				smbt_pkg::ST_WO_UPD: begin
					// phase 0: e*h, phase 1: eta*(e*h) via acc as a, phase 2: write
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						who_q[j_q][k_q] <= smbt_pkg::sat_w(48'(who_q[j_q][k_q]) - fl24);
						ph_q <= '0;
						k_q <= k_last ? '0 : k_q + 1'b1;
						if (k_last) j_q <= j_last ? '0 : j_q + 1'b1;
					end
				end
				smbt_pkg::ST_BE_ACC: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						ph_q <= '0; k_q <= k_last ? '0 : k_q + 1'b1;
					end
				end
				smbt_pkg::ST_WI_UPD: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						wih_q[iw_q[VW-1:0]][j_q] <=
							smbt_pkg::sat_w(48'(wih_q[iw_q[VW-1:0]][j_q]) - fl12);
						ph_q <= '0; j_q <= j_last ? '0 : j_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != smbt_pkg::ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && last_q |-> node_q == 2'(VOCAB_SIZE - 1)) else $error("bad last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ch.ready |=> ovalid_q) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/smbt_checker.sv =====
// Checker for the sigmoid MLP backprop trainer: watches the item channels and the APB port,
// predicts the activations of each training pair and compares them with the block's output.
// Depends on nothing but the port signals handed in by the testbench top.
module smbt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Vocab  = 4;
	localparam int Hidden = 2;
	localparam int WMax   = 32767;
	localparam int WMin   = -32768;
	localparam int SigLut[17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
		4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};

	typedef struct packed {
		logic [1:0]  node;
		logic [12:0] act;
		logic        last;
	} act_t;

	int   w_in[Vocab][Hidden];
	int   w_out[Hidden][Vocab];
	int   eta;
	act_t act_queue[$];

	assign pending = act_queue.size();

	// piecewise-linear sigmoid in Q.12
	function automatic int sigm(longint x);
		longint a;
		int     v;
		int     i;
		int     f;
		a = (x < 0) ? -x : x;
		if (a >= 32768) begin
			v = SigLut[16];
		end else begin
			i = int'(a >> 11);
			f = int'(a & 2047);
			v = SigLut[i] + (((SigLut[i+1] - SigLut[i]) * f) >>> 11);
		end
		return (x < 0) ? 4096 - v : v;
	endfunction

	function automatic int clamp_w(longint v);
		if (v > WMax) return WMax;
		if (v < WMin) return WMin;
		return int'(v);
	endfunction

	// run one training pair: queue the activations, then move the weights
	task automatic train_pair(int iw, int tw);
		int     h[Hidden];
		int     e[Vocab];
		longint acc;
		int     y;
		act_t   a;
		for (int j = 0; j < Hidden; j++) h[j] = sigm(w_in[iw][j]);
		for (int k = 0; k < Vocab; k++) begin
			acc = 0;
			for (int j = 0; j < Hidden; j++) acc += longint'(w_out[j][k]) * h[j];
			y = sigm(acc >>> 12);
			e[k] = y - ((k == tw) ? 4096 : 0);
			a.node = k[1:0];
			a.act  = y[12:0];
			a.last = (k == Vocab - 1);
			act_queue.insert(act_queue.size(), a);
		end
		for (int j = 0; j < Hidden; j++)
			for (int k = 0; k < Vocab; k++)
				w_out[j][k] = clamp_w(longint'(w_out[j][k]) -
					((longint'(eta) * e[k] * h[j]) >>> 24));
		for (int j = 0; j < Hidden; j++) begin
			acc = 0;
			for (int k = 0; k < Vocab; k++) acc += longint'(e[k]) * w_out[j][k];
			acc = acc >>> 12;
			w_in[iw][j] = clamp_w(longint'(w_in[iw][j]) - ((longint'(eta) * acc) >>> 12));
		end
	endtask

	// observe transactions on every port
	always @(posedge clk or negedge arst_n) begin
		act_t got;
		act_t want;
		if (!arst_n) begin
			for (int i = 0; i < Vocab; i++)
				for (int j = 0; j < Hidden; j++) begin
					w_in[i][j]  = 4096;
					w_out[j][i] = 4096;
				end
			eta = 410;
			fail_count = 0;
			act_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
				eta = int'(pwdata[12:0]);
			if (out_valid && out_ready) begin
				got = out_data;
				if (act_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected activation node=%0d act=%0d last=%0d",
						$time, got.node, got.act, got.last);
				end else begin
					want = act_queue.pop_front();
					if (got !== want) begin
						fail_count++;
						$display({"%0t: mismatch expected node=%0d act=%0d last=%0d,",
							" got node=%0d act=%0d last=%0d"},
							$time, want.node, want.act, want.last,
							got.node, got.act, got.last);
					end
				end
			end
			if (in_valid && in_ready)
				train_pair(int'(in_data[3:2]), int'(in_data[1:0]));
		end
	end
endmodule

// ===== tb/sv/tb_sigmoid_mlp_backprop_trainer_unit.sv =====
// Testbench top for the sigmoid MLP backprop trainer: drives training pairs and APB writes
// under several idling phases and gives the verdict. Depends on smbt_pkg, smbt_if, smbt_checker.
module tb_sigmoid_mlp_backprop_trainer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] input_word;
		logic [1:0] target_word;
	} pair_t;

	typedef struct packed {
		logic [1:0]             node_index;
		logic [smbt_pkg::ActW-1:0] activation_value;
		logic                   last_node;
	} node_act_t;

	localparam int CycleLimit = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          idle_mode = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	smbt_if #(.payload_t(pair_t))     in_ch ();
	smbt_if #(.payload_t(node_act_t)) out_ch ();

	sigmoid_mlp_backprop_trainer_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	smbt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	always #6 clk = ~clk;

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_mode == 2) begin
			out_ch.ready <= ($urandom_range(99) >= 70);
		end else if (idle_mode == 3) begin
			out_ch.ready <= ($urandom_range(99) >= 12);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	function automatic bit sender_idles();
		if (idle_mode == 1) return $urandom_range(99) < 70;
		if (idle_mode == 3) return $urandom_range(99) < 12;
		return 1'b0;
	endfunction

	task automatic send_pair(logic [1:0] iw, logic [1:0] tw);
		@(negedge clk);
		while (sender_idles()) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{input_word: iw, target_word: tw};
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drop valid and wait for every activation plus the weight-update tail
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		logic [12:0] eta_list[6];
		eta_list = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'd410, 13'd0};
		eta_list[5] = 13'($urandom_range(8191));
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every input/target pair at reset rate, then extremes of eta
		for (int i = 0; i < 4; i++)
			for (int t = 0; t < 4; t++) send_pair(i[1:0], t[1:0]);
		drain();
		apb_write(3'd4, 32'hffff_ffff);
		apb_write(3'd0, 32'h0000_1fff);
		send_pair(2'd3, 2'd0);
		send_pair(2'd0, 2'd3);
		drain();
		apb_write(3'd0, 32'hffff_e000);
		send_pair(2'd1, 2'd2);
		send_pair(2'd2, 2'd1);
		drain();

		// random phases under each idling mode
		for (int p = 0; p < 6; p++) begin
			apb_write(3'd0, {19'($urandom), eta_list[p]});
			idle_mode = p % 4;
			for (int n = 0; n < 32; n++) begin
				if (p == 2 && n == 5) hold_req = 1'b1;
				if (p == 4 && n == 17) begin
					@(negedge clk);
					in_ch.valid <= 1'b0;
					while (pending != 0) @(posedge clk);
				end
				send_pair(2'($urandom), 2'($urandom));
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
